// ----- design/psdf_pkg.sv -----
// ----------------------------------------------------------------------------
// psdf_pkg
// Shared types, constants and helpers for the polyhedron plane SDF evaluator.
// ----------------------------------------------------------------------------
package psdf_pkg;

  localparam int MAX_PLANES   = 16;
  localparam int PLANE_IDX_W  = $clog2(MAX_PLANES);
  localparam int MAX_HALF_EXP = 8;
  localparam int COORD_W      = 24;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int DOT_W        = PROD_W + 2;
  localparam int TERM_W       = 48;
  localparam int ACC_W        = 2 * TERM_W;
  localparam int DIV_CNT_W    = 6;
  localparam int ROOT_MSB     = 32;
  localparam int ROOT_W       = ROOT_MSB + 1;
  localparam int BIT_W        = 6;
  localparam int RES_W        = 36;
  localparam int MAXV_W       = 35;

  localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};
  localparam logic signed [RES_W-1:0] FIX_ONE = 36'sd65536;
  localparam logic signed [RES_W-1:0] OUT_MAX = 36'sd8388607;
  localparam logic signed [RES_W-1:0] OUT_MIN = -36'sd8388608;

  // Configuration register indexes
  localparam logic CFG_EXP_HALF   = 1'b0;
  localparam logic CFG_PLANE_CNT  = 1'b1;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DOT,
    ST_MAXUP,
    ST_DIV,
    ST_POW,
    ST_SUM,
    ST_RCMP,
    ST_FIN
  } state_t;

  // Magnitude of a signed coordinate; the most negative value maps to 2^23.
  function automatic logic [COORD_W-1:0] mag24(input coord_t v);
    logic [COORD_W-1:0] m;
    m = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    return m;
  endfunction

endpackage

// ----- design/psdf_mul.sv -----
// ----------------------------------------------------------------------------
// psdf_mul
// Shared 24x24 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module psdf_mul (
  input  logic                          clk,
  input  logic [psdf_pkg::COORD_W-1:0]  a,
  input  logic [psdf_pkg::COORD_W-1:0]  b,
  output logic [psdf_pkg::PROD_W-1:0]   p_r
);
  import psdf_pkg::*;

  // product register
  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- design/psdf_div.sv -----
// ----------------------------------------------------------------------------
// psdf_div
// Restoring divider, 48-bit dividend by 24-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psdf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psdf_pkg::TERM_W-1:0]   dividend,
  input  logic [psdf_pkg::COORD_W-1:0]  divisor,
  output logic                          done_r,
  output logic [psdf_pkg::TERM_W-1:0]   quot_r
);
  import psdf_pkg::*;

  logic [COORD_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [COORD_W:0]     trial;
  logic                 fits;

  // trial subtract
  assign trial = {rem_r, quot_r[TERM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(TERM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= fits ? COORD_W'(trial - {1'b0, divisor}) : COORD_W'(trial);
      quot_r <= {quot_r[TERM_W-2:0], fits};
    end
  end

endmodule

// ----- design/polyhedron_plane_sdf_eval.sv -----
// ----------------------------------------------------------------------------
// polyhedron_plane_sdf_eval
// Signed distance to a convex polyhedron from a table of planes.
// ----------------------------------------------------------------------------
// Load items (opcode 0) each write one plane and can be taken back to back.
// An evaluate item runs a sequencer around one shared 24x24 multiplier and
// one serial divider and is not accepted back to back: per plane it fetches
// the plane and forms the dot product, then in max mode updates the maximum,
// or in norm mode divides and raises the quotient to the power 2k; in norm
// mode the root then follows bit by bit. A 48x48 power multiply is four
// partial products through the shared multiplier. A finished result waits in
// the output register while the next item is taken.
// ----------------------------------------------------------------------------
module polyhedron_plane_sdf_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [3:0]           in_plane_slot,
  input  psdf_pkg::coord_t     in_coord_x,
  input  psdf_pkg::coord_t     in_coord_y,
  input  psdf_pkg::coord_t     in_coord_z,
  input  psdf_pkg::coord_t     in_plane_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psdf_pkg::coord_t     out_distance,
  output logic                 out_clipped
);
  import psdf_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0] exp_half_r;
  logic [4:0] plane_cnt_r;

  coord_t nx_mem [MAX_PLANES];
  coord_t ny_mem [MAX_PLANES];
  coord_t nz_mem [MAX_PLANES];
  coord_t off_mem[MAX_PLANES];

  coord_t nx_r, ny_r, nz_r, off_r, px_r, py_r, pz_r;
  logic [PLANE_IDX_W-1:0] idx_r, last_idx;
  logic [2:0]             step_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [MAXV_W-1:0] best_r, mx_v;
  logic [TERM_W-1:0]  r_r, t_r, sum_r;
  logic [ACC_W-1:0]   acc_r;
  logic [3:0]         iter_r, e_m1;
  logic               psat_r, root_r, clip_r;
  logic [ROOT_W-1:0]  y_r, y_new;
  logic [BIT_W-1:0]   bit_r;
  logic signed [RES_W-1:0] result_r;
  logic [3:0]         keff;

  logic               out_valid_r, out_clip_r;
  coord_t             out_dist_r;

  logic [COORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start, div_done;
  logic [TERM_W-1:0]  div_q, dot_abs;
  logic [1:0]         pp_j;
  logic [ACC_W-1:0]   pp_sh;
  logic               dot_neg, pow_sat, pow_last, fin_go, root_ok;
  logic [TERM_W-1:0]  t_mul;
  logic [3:0]         iter_inc;

  // effective exponent and plane count
  assign keff = (exp_half_r > 4'(MAX_HALF_EXP)) ? 4'(MAX_HALF_EXP) : exp_half_r;
  assign e_m1 = 4'({keff, 1'b0} - 5'd1);
  always_comb begin
    if (plane_cnt_r == 5'd0)
      last_idx = '0;
    else if (plane_cnt_r > 5'(MAX_PLANES))
      last_idx = PLANE_IDX_W'(MAX_PLANES - 1);
    else
      last_idx = PLANE_IDX_W'(plane_cnt_r - 5'd1);
  end

  // shared units
  psdf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  assign dot_abs = dot_r[DOT_W-1] ? TERM_W'(-dot_r) : TERM_W'(dot_r);

  psdf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dot_abs),
    .divisor(mag24(off_r)), .done_r(div_done), .quot_r(div_q)
  );

  // partial product alignment and sign
  assign pp_j = 2'(step_r - 3'd1);
  always_comb begin
    case (pp_j)
      2'd0:    pp_sh = ACC_W'(mul_p);
      2'd1:    pp_sh = ACC_W'(mul_p) << COORD_W;
      2'd2:    pp_sh = ACC_W'(mul_p) << COORD_W;
      default: pp_sh = ACC_W'(mul_p) << (2 * COORD_W);
    endcase
    case (pp_j)
      2'd0:    dot_neg = nx_r[COORD_W-1] ^ px_r[COORD_W-1];
      2'd1:    dot_neg = ny_r[COORD_W-1] ^ py_r[COORD_W-1];
      default: dot_neg = nz_r[COORD_W-1] ^ pz_r[COORD_W-1];
    endcase
  end

  assign mx_v     = MAXV_W'(dot_r >>> 16) - MAXV_W'(off_r);
  assign pow_sat  = acc_r[ACC_W-1:64] != '0;
  assign t_mul    = acc_r[63:16];
  assign iter_inc = iter_r + 4'd1;
  assign pow_last = pow_sat || (iter_inc == e_m1);
  assign fin_go   = !out_valid_r || out_ready;
  assign root_ok  = !psat_r && (t_r <= sum_r);
  assign y_new    = root_ok ? ROOT_W'(r_r) : y_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid && in_opcode == OP_EVAL) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_DOT;
      ST_DOT: begin
        if (step_r == 3'd3) begin
          if (keff == 4'd0)        state_nxt = ST_MAXUP;
          else if (off_r == '0)    state_nxt = ST_SUM;
          else                     state_nxt = ST_DIV;
        end
      end
      ST_MAXUP: state_nxt = (idx_r == last_idx) ? ST_FIN : ST_FETCH;
      ST_DIV:   if (div_done) state_nxt = ST_POW;
      ST_POW: begin
        if (step_r == 3'd5 && pow_last) state_nxt = root_r ? ST_RCMP : ST_SUM;
      end
      ST_SUM:   state_nxt = (idx_r == last_idx) ? ST_POW : ST_FETCH;
      ST_RCMP:  state_nxt = (bit_r == '0) ? ST_FIN : ST_POW;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = state_r == ST_IDLE;
    div_start = state_r == ST_DIV && step_r == 3'd0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_DOT: begin
        case (step_r)
          3'd0: begin mul_a = mag24(nx_r); mul_b = mag24(px_r); end
          3'd1: begin mul_a = mag24(ny_r); mul_b = mag24(py_r); end
          3'd2: begin mul_a = mag24(nz_r); mul_b = mag24(pz_r); end
          default: ;
        endcase
      end
      ST_POW: begin
        mul_a = step_r[1] ? t_r[TERM_W-1:COORD_W] : t_r[COORD_W-1:0];
        mul_b = step_r[0] ? r_r[TERM_W-1:COORD_W] : r_r[COORD_W-1:0];
      end
      default: ;
    endcase
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_half_r  <= '0;
      plane_cnt_r <= 5'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXP_HALF:  exp_half_r  <= cfg_data[3:0];
          CFG_PLANE_CNT: plane_cnt_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_FIN && fin_go) out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
    end
  end

  // plane table
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_opcode == OP_LOAD) begin
      nx_mem[in_plane_slot]  <= in_coord_x;
      ny_mem[in_plane_slot]  <= in_coord_y;
      nz_mem[in_plane_slot]  <= in_coord_z;
      off_mem[in_plane_slot] <= in_plane_offset;
    end
    if (state_r == ST_FETCH) begin
      nx_r  <= nx_mem[idx_r];
      ny_r  <= ny_mem[idx_r];
      nz_r  <= nz_mem[idx_r];
      off_r <= off_mem[idx_r];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r   <= in_coord_x;
        py_r   <= in_coord_y;
        pz_r   <= in_coord_z;
        idx_r  <= '0;
        clip_r <= 1'b0;
        sum_r  <= '0;
        y_r    <= '0;
        root_r <= 1'b0;
      end
      ST_FETCH: begin
        step_r <= '0;
        dot_r  <= '0;
      end
      ST_DOT: begin
        if (step_r != 3'd0)
          dot_r <= dot_neg ? dot_r - DOT_W'(mul_p) : dot_r + DOT_W'(mul_p);
        step_r <= (step_r == 3'd3) ? 3'd0 : step_r + 3'd1;
        if (step_r == 3'd3 && keff != 4'd0 && off_r == '0) begin
          t_r    <= TERM_CAP;
          psat_r <= 1'b1;
        end
      end
      ST_MAXUP: begin
        if (idx_r == '0 || mx_v > best_r) best_r <= mx_v;
        if (idx_r == '0 || mx_v > best_r) result_r <= RES_W'(mx_v);
        else                              result_r <= RES_W'(best_r);
        idx_r <= idx_r + 1'b1;
      end
      ST_DIV: begin
        step_r <= 3'd1;
        if (div_done) begin
          r_r    <= div_q;
          t_r    <= div_q;
          iter_r <= '0;
          psat_r <= 1'b0;
          step_r <= '0;
        end
      end
      ST_POW: begin
        if (step_r == 3'd0)
          acc_r <= '0;
        else if (step_r != 3'd5)
          acc_r <= acc_r + pp_sh;
        if (step_r == 3'd5) begin
          step_r <= '0;
          iter_r <= iter_inc;
          if (pow_sat) begin
            t_r    <= TERM_CAP;
            psat_r <= 1'b1;
          end else begin
            t_r <= t_mul;
          end
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
      ST_SUM: begin
        if (psat_r) clip_r <= 1'b1;
        if (t_r > TERM_CAP - sum_r) begin
          sum_r  <= TERM_CAP;
          clip_r <= 1'b1;
        end else begin
          sum_r <= sum_r + t_r;
        end
        idx_r <= idx_r + 1'b1;
        // first root candidate; root mode only after the last plane
        r_r    <= TERM_W'(1) << ROOT_MSB;
        t_r    <= TERM_W'(1) << ROOT_MSB;
        bit_r  <= BIT_W'(ROOT_MSB);
        root_r <= (idx_r == last_idx);
        iter_r <= '0;
        psat_r <= 1'b0;
        step_r <= '0;
      end
      ST_RCMP: begin
        y_r <= y_new;
        if (bit_r == '0) begin
          result_r <= RES_W'(y_new) - FIX_ONE;
        end else begin
          r_r    <= TERM_W'(y_new | (ROOT_W'(1) << (bit_r - 1'b1)));
          t_r    <= TERM_W'(y_new | (ROOT_W'(1) << (bit_r - 1'b1)));
          bit_r  <= bit_r - 1'b1;
          iter_r <= '0;
          psat_r <= 1'b0;
          step_r <= '0;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          if (result_r > OUT_MAX) begin
            out_dist_r <= coord_t'(OUT_MAX);
            out_clip_r <= 1'b1;
          end else if (result_r < OUT_MIN) begin
            out_dist_r <= coord_t'(OUT_MIN);
            out_clip_r <= 1'b1;
          end else begin
            out_dist_r <= coord_t'(result_r);
            out_clip_r <= clip_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_clipped  = out_clip_r;

endmodule

// ----- design/psdf_checker.sv -----
// ----------------------------------------------------------------------------
// psdf_checker
// Port-level checks on the plane SDF evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module psdf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input psdf_pkg::coord_t     out_distance
);
  import psdf_pkg::*;

  // an evaluate item keeps the block busy on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_EVAL |=> !in_ready)
    else $error("block ready right after an evaluate item");

  // a load item never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_LOAD |=> !$rose(out_valid))
    else $error("result appeared after a load item");

  // a new result only comes out of a busy evaluation
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("stalled result changed");

endmodule

bind polyhedron_plane_sdf_eval psdf_checker u_psdf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_opcode(in_opcode), .out_valid(out_valid), .out_ready(out_ready),
  .out_distance(out_distance)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polyhedron plane SDF evaluator: loads the plane
// table, evaluates points in max and norm modes over many register settings,
// and checks every distance against a built-in predictor under random idling.
// ----------------------------------------------------------------------------
module testbench;
  import psdf_pkg::*;

  localparam logic [63:0] CAP64 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    coord_t dval;
    logic   clip;
  } dist_exp_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       in_opcode;
  logic [3:0] in_plane_slot;
  coord_t     in_coord_x;
  coord_t     in_coord_y;
  coord_t     in_coord_z;
  coord_t     in_plane_offset;
  logic       out_valid;
  logic       out_ready;
  coord_t     out_distance;
  logic       out_clipped;

  // predictor state
  coord_t     tbl_nx [MAX_PLANES];
  coord_t     tbl_ny [MAX_PLANES];
  coord_t     tbl_nz [MAX_PLANES];
  coord_t     tbl_w  [MAX_PLANES];
  int         pred_half_exp;
  int         pred_count;

  dist_exp_t  pending_dist [$];
  int         mismatch_cnt;
  int         load_cnt;
  int         eval_cnt;
  int         checked_cnt;
  int         rx_hold_req;
  bit         quiet_mode;

  polyhedron_plane_sdf_eval DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_plane_slot(in_plane_slot),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_plane_offset(in_plane_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance(out_distance), .out_clipped(out_clipped)
  );

  always #5 clk = ~clk;

  // r^e with truncating Q.16 multiplies; saturates on 64-bit overflow
  function automatic logic [63:0] raise_q16(input logic [63:0] r, input int e,
                                            output logic sat);
    logic [127:0] p;
    logic [63:0]  t;
    sat = 1'b0;
    t = r;
    if (r > CAP64) begin
      sat = 1'b1;
      return CAP64;
    end
    for (int i = 1; i < e; i++) begin
      p = {64'd0, t} * {64'd0, r};
      if (p[127:64] != 0) begin
        sat = 1'b1;
        return CAP64;
      end
      t = p[79:16];
    end
    return t;
  endfunction

  // expected distance of a point against the first planes of the table
  function automatic dist_exp_t plane_sdf_predict(input coord_t px, py, pz);
    dist_exp_t   res;
    int          cnt, k, e;
    longint      d, v, best, dist_val;
    logic [63:0] ad, aw, term, sum, y, cand, pw;
    logic        clip, s;
    clip = 1'b0;
    cnt = (pred_count < 1) ? 1 : (pred_count > MAX_PLANES) ? MAX_PLANES : pred_count;
    k = (pred_half_exp > MAX_HALF_EXP) ? MAX_HALF_EXP : pred_half_exp;
    best = 0;
    sum = 0;
    y = 0;
    e = 2 * k;
    for (int i = 0; i < cnt; i++) begin
      d = longint'(tbl_nx[i]) * longint'(px) + longint'(tbl_ny[i]) * longint'(py)
        + longint'(tbl_nz[i]) * longint'(pz);
      if (k == 0) begin
        v = (d >>> 16) - longint'(tbl_w[i]);
        if (i == 0 || v > best) best = v;
      end else begin
        if (tbl_w[i] == 0) begin
          term = CAP64;
          clip = 1'b1;
        end else begin
          ad = (d < 0) ? -d : d;
          aw = (tbl_w[i] < 0) ? -longint'(tbl_w[i]) : longint'(tbl_w[i]);
          term = raise_q16(ad / aw, e, s);
          if (s) clip = 1'b1;
        end
        if (term > CAP64 - sum) begin
          sum = CAP64;
          clip = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    if (k == 0) begin
      dist_val = best;
    end else begin
      for (int b = ROOT_MSB; b >= 0; b--) begin
        cand = y | (64'd1 << b);
        pw = raise_q16(cand, e, s);
        if (!s && pw <= sum) y = cand;
      end
      dist_val = longint'(y) - 65536;
    end
    if (dist_val > 8388607) begin
      dist_val = 8388607;
      clip = 1'b1;
    end else if (dist_val < -8388608) begin
      dist_val = -8388608;
      clip = 1'b1;
    end
    res.dval = dist_val[23:0];
    res.clip = clip;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet_mode || sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return '0;
      3, 4, 5: return coord_t'($urandom_range(0, 1 << 18)) - coord_t'(1 << 17);
      6, 7: return coord_t'($urandom_range(0, 1 << 21)) - coord_t'(1 << 20);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // send one item; predicts at the accepting edge
  task automatic send_item(input logic op, input logic [3:0] slot,
                           input coord_t x, y, z, w);
    int  gap;
    bit  acc;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_plane_slot   <= slot;
    in_coord_x      <= x;
    in_coord_y      <= y;
    in_coord_z      <= z;
    in_plane_offset <= w;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    if (op == OP_LOAD) begin
      tbl_nx[slot] = x;
      tbl_ny[slot] = y;
      tbl_nz[slot] = z;
      tbl_w[slot]  = w;
      load_cnt++;
    end else begin
      pending_dist.push_back(plane_sdf_predict(x, y, z));
      eval_cnt++;
    end
  endtask

  task automatic eval_point(input coord_t x, y, z);
    send_item(OP_EVAL, 4'($urandom), x, y, z, coord_t'($urandom));
  endtask

  // idle the input, wait for all results, let a trailing load finish
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_dist.size() != 0 && waited < 2000000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_EXP_HALF) pred_half_exp = val[3:0];
    else pred_count = val;
  endtask

  // ---- tests ----

  task automatic test_table_load();
    send_item(OP_LOAD, 4'd0, 24'sh010000, 24'sh0, 24'sh0, 24'sh010000);
    send_item(OP_LOAD, 4'd1, 24'sh0, 24'sh010000, 24'sh0, 24'sh010000);
    send_item(OP_LOAD, 4'd2, 24'sh0, 24'sh0, 24'sh010000, 24'sh0);
    send_item(OP_LOAD, 4'd3, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
    for (int s = 4; s < MAX_PLANES; s++)
      send_item(OP_LOAD, s[3:0], rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_max_mode();
    write_reg(CFG_EXP_HALF, 5'd0);
    write_reg(CFG_PLANE_CNT, 5'd16);
    eval_point(24'sh0, 24'sh0, 24'sh0);
    eval_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    eval_point(24'sh800000, 24'sh800000, 24'sh800000);
    // count above table size clamps
    write_reg(CFG_PLANE_CNT, 5'd31);
    eval_point(24'sh800000, 24'sh7FFFFF, 24'sh800000);
  endtask

  task automatic test_norm_mode();
    write_reg(CFG_EXP_HALF, 5'd1);
    write_reg(CFG_PLANE_CNT, 5'd2);
    eval_point(24'sh010000, 24'sh010000, 24'sh0);
    eval_point(24'sh0, 24'sh0, 24'sh0);
    // third plane has zero offset
    write_reg(CFG_PLANE_CNT, 5'd3);
    eval_point(24'sh008000, 24'sh004000, 24'sh002000);
    // exponent above limit, count of zero
    write_reg(CFG_EXP_HALF, 5'd31);
    write_reg(CFG_PLANE_CNT, 5'd0);
    eval_point(24'sh018000, 24'sh7FFFFF, 24'sh800000);
    write_reg(CFG_EXP_HALF, 5'd8);
    eval_point(24'sh7FFFFF, 24'sh0, 24'sh0);
  endtask

  task automatic test_random_mix();
    int sel, cnt;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_EXP_HALF, (ph % 4 == 0) ? 5'd0 : 5'($urandom_range(0, 31)));
      sel = $urandom_range(0, 99);
      cnt = (sel < 80) ? $urandom_range(1, 4) :
            (sel < 95) ? $urandom_range(5, 16) : $urandom_range(0, 31);
      write_reg(CFG_PLANE_CNT, cnt[4:0]);
      quiet_mode = (ph == 5);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 9) < 3)
          send_item(OP_LOAD, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
        else
          eval_point(rand_coord(), rand_coord(), rand_coord());
      end
      quiet_mode = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    write_reg(CFG_EXP_HALF, 5'd0);
    write_reg(CFG_PLANE_CNT, 5'd1);
    rx_hold_req = 1500;
    quiet_mode = 1'b1;
    for (int i = 0; i < 8; i++) eval_point(rand_coord(), rand_coord(), rand_coord());
    quiet_mode = 1'b0;
  endtask

  // ---- result side ----

  always @(posedge clk) begin : rx_ready_gen
    int stall_left;
    if (rx_hold_req > 0) begin
      stall_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (quiet_mode) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // outputs are stable between edges; a handshake seen here lands at the next edge
  always @(negedge clk) begin : dist_check
    dist_exp_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dist.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected result dist=%0d clip=%0b", out_distance, out_clipped);
      end else begin
        exp_r = pending_dist.pop_front();
        checked_cnt++;
        if (out_distance !== exp_r.dval || out_clipped !== exp_r.clip) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result %0d exp dist=%0d clip=%0b got dist=%0d clip=%0b",
                     checked_cnt, exp_r.dval, exp_r.clip, out_distance, out_clipped);
        end
      end
    end
  end

  initial begin
    #200000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_plane_slot = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_plane_offset = '0;
    pred_half_exp = 0;
    pred_count = 1;
    mismatch_cnt = 0;
    load_cnt = 0;
    eval_cnt = 0;
    checked_cnt = 0;
    rx_hold_req = 0;
    quiet_mode = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_max_mode();
    test_norm_mode();
    test_random_mix();
    test_output_stall();
    drain();
    repeat (50) @(posedge clk);
    if (pending_dist.size() != 0) mismatch_cnt++;

    $display("Covered %0d plane loads and %0d point evaluations, %0d distances checked,",
             load_cnt, eval_cnt, checked_cnt);
    $display("max and norm modes with clamped exponents and counts, %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/psdf_pkg.sv
design/psdf_mul.sv
design/psdf_div.sv
design/polyhedron_plane_sdf_eval.sv
design/psdf_checker.sv
tb/testbench.sv
